@@ rtl/core/crpc_pkg.sv @@
// Shared types and constants for the Content-Range parse and check core.
// No dependencies; used by crpc_parse, crpc_check and the top level.

package crpc_pkg;

    localparam int unsigned NUM_W = 64;

    // configuration register indexes
    localparam logic CFG_REQ_FIRST = 1'b0;
    localparam logic CFG_REQ_LAST  = 1'b1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2d;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    // "bytes " by position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (pos)
            3'd0: ch = 8'h62;
            3'd1: ch = 8'h79;
            3'd2: ch = 8'h74;
            3'd3: ch = 8'h65;
            3'd4: ch = 8'h73;
            3'd5: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // parsed header value, handed from the parser to the range check
    typedef struct packed {
        logic             vld;
        logic             range_valid;
        logic [NUM_W-1:0] first;
        logic [NUM_W-1:0] last;
        logic             total_ok;
        logic [NUM_W-1:0] total;
    } t_snap;

endpackage

@@ rtl/core/crpc_parse.sv @@
// Input register and per-character parser state for the Content-Range core.
// Depends on crpc_pkg (character constants, prefix text, t_snap).

module crpc_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_in_valid,
    input  logic [7:0]                 i_value_char,
    input  logic                       i_final_char,
    output crpc_pkg::t_snap            o_snap
);

    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_LAST   = 3'd2;
    localparam logic [2:0] PH_TOTAL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_BAD    = 3'd5;

    localparam int unsigned W = crpc_pkg::NUM_W;

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_final;

    logic [2:0]   r_phase, n_phase;
    logic [2:0]   r_prefix_pos, n_prefix_pos;
    logic [W-1:0] r_first, n_first;
    logic [W-1:0] r_last, n_last;
    logic [W-1:0] r_total, n_total;
    logic         r_digits, n_digits;
    logic         r_ovf, n_ovf;

    crpc_pkg::t_snap r_snap;

    logic         is_digit;
    logic [3:0]   digit;
    logic [W-1:0] acc;
    logic [W+3:0] acc_ext;
    logic [W+3:0] prod;
    logic         prod_ovf;
    logic         close_ok;
    logic         step;
    logic         end_valid;
    logic         end_total_ok;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_in_valid) begin
            r_in_char  <= i_value_char;
            r_in_final <= i_final_char;
        end
    end

    assign step     = i_adv && r_in_valid;
    assign is_digit = (r_in_char >= crpc_pkg::CHAR_ZERO) && (r_in_char <= crpc_pkg::CHAR_NINE);
    assign digit    = r_in_char[3:0];

    // one accumulator datapath shared by the three numbers
    always_comb begin
        case (r_phase)
            PH_LAST:  acc = r_last;
            PH_TOTAL: acc = r_total;
            default:  acc = r_first;
        endcase
    end

    // acc*10 + d; anything above bit 63 means it no longer fits
    assign acc_ext  = {4'b0000, acc};
    assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{W{1'b0}}, digit};
    assign prod_ovf = |prod[W+3:W];
    assign close_ok = r_digits && !r_ovf;

    always_comb begin
        n_phase      = r_phase;
        n_prefix_pos = r_prefix_pos;
        n_first      = r_first;
        n_last       = r_last;
        n_total      = r_total;
        n_digits     = r_digits;
        n_ovf        = r_ovf;

        unique case (r_phase) inside
            PH_PREFIX: begin
                if (r_prefix_pos < crpc_pkg::PREFIX_LEN &&
                    r_in_char == crpc_pkg::prefix_char(r_prefix_pos)) begin
                    n_prefix_pos = r_prefix_pos + 3'd1;
                    if (r_prefix_pos == crpc_pkg::PREFIX_LEN - 3'd1) begin
                        n_phase = PH_FIRST;
                    end
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_FIRST, PH_LAST, PH_TOTAL: begin
                if (is_digit) begin
                    n_digits = 1'b1;
                    if (!r_ovf) begin
                        if (prod_ovf) begin
                            n_ovf = 1'b1;
                        end else if (r_phase == PH_FIRST) begin
                            n_first = prod[W-1:0];
                        end else if (r_phase == PH_LAST) begin
                            n_last = prod[W-1:0];
                        end else begin
                            n_total = prod[W-1:0];
                        end
                    end
                end else if (r_phase == PH_TOTAL) begin
                    // total keeps its digit/overflow status for the result
                    n_phase = PH_DONE;
                end else begin
                    n_digits = 1'b0;
                    n_ovf    = 1'b0;
                    if (close_ok && r_phase == PH_FIRST && r_in_char == crpc_pkg::CHAR_DASH) begin
                        n_phase = PH_LAST;
                    end else if (close_ok && r_phase == PH_LAST &&
                                 r_in_char == crpc_pkg::CHAR_SLASH) begin
                        n_phase = PH_TOTAL;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PREFIX;
            r_prefix_pos <= 3'd0;
            r_first      <= '0;
            r_last       <= '0;
            r_total      <= '0;
            r_digits     <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (step) begin
            if (r_in_final) begin
                r_phase      <= PH_PREFIX;
                r_prefix_pos <= 3'd0;
                r_first      <= '0;
                r_last       <= '0;
                r_total      <= '0;
                r_digits     <= 1'b0;
                r_ovf        <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_prefix_pos <= n_prefix_pos;
                r_first      <= n_first;
                r_last       <= n_last;
                r_total      <= n_total;
                r_digits     <= n_digits;
                r_ovf        <= n_ovf;
            end
        end
    end

    assign end_valid    = (n_phase == PH_TOTAL) || (n_phase == PH_DONE);
    assign end_total_ok = end_valid && n_digits && !n_ovf;

    // snapshot of the finished header value; fields zeroed when not valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap <= '0;
        end else begin
            if (i_adv) begin
                r_snap.vld <= r_in_valid && r_in_final;
            end
            if (step && r_in_final) begin
                r_snap.range_valid <= end_valid;
                r_snap.first       <= end_valid ? n_first : '0;
                r_snap.last        <= end_valid ? n_last : '0;
                r_snap.total_ok    <= end_total_ok;
                r_snap.total       <= end_total_ok ? n_total : '0;
            end
        end
    end

    assign o_snap = r_snap;

    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_final) |=> (r_phase == PH_PREFIX && r_prefix_pos == 3'd0 &&
                                  !r_digits && !r_ovf))
        else $error("parser state not cleared after final character");

    a_prefix_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST) |-> (r_prefix_pos == crpc_pkg::PREFIX_LEN))
        else $error("number phase entered without full prefix");

    a_snap_only_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_snap.vld) |-> $past(r_in_valid && r_in_final))
        else $error("snapshot without a final character");

endmodule

@@ rtl/core/crpc_check.sv @@
// Range check against the wanted range and the result register.
// Depends on crpc_pkg (t_snap, NUM_W).

module crpc_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  crpc_pkg::t_snap              i_snap,
    input  logic [crpc_pkg::NUM_W-1:0]   i_req_first,
    input  logic [crpc_pkg::NUM_W-1:0]   i_req_last,
    output logic                         o_valid,
    output logic                         o_range_valid,
    output logic [crpc_pkg::NUM_W-1:0]   o_range_first,
    output logic [crpc_pkg::NUM_W-1:0]   o_range_last,
    output logic                         o_total_present,
    output logic [crpc_pkg::NUM_W-1:0]   o_total_length,
    output logic                         o_other_range
);

    localparam int unsigned W = crpc_pkg::NUM_W;

    logic         r_valid;
    logic         r_range_valid;
    logic [W-1:0] r_first;
    logic [W-1:0] r_last;
    logic         r_total_ok;
    logic [W-1:0] r_total;
    logic         r_other;

    logic [W-1:0] last_inc;
    logic         other;

    // last+1 wraps at 64 bits, as does the total compare
    assign last_inc = i_snap.last + {{(W-1){1'b0}}, 1'b1};

    always_comb begin
        other = 1'b0;
        if (i_snap.range_valid) begin
            if (i_snap.first != i_req_first || i_snap.last > i_req_last) begin
                other = 1'b1;
            end else if (i_snap.last == i_req_last) begin
                other = 1'b0;
            end else begin
                other = !i_snap.total_ok || (last_inc != i_snap.total);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_snap.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_snap.vld) begin
            r_range_valid <= i_snap.range_valid;
            r_first       <= i_snap.first;
            r_last        <= i_snap.last;
            r_total_ok    <= i_snap.total_ok;
            r_total       <= i_snap.total;
            r_other       <= other;
        end
    end

    assign o_valid         = r_valid;
    assign o_range_valid   = r_range_valid;
    assign o_range_first   = r_first;
    assign o_range_last    = r_last;
    assign o_total_present = r_total_ok;
    assign o_total_length  = r_total;
    assign o_other_range   = r_other;

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_range_valid) |-> (r_first == '0 && r_last == '0 &&
                                         !r_total_ok && !r_other))
        else $error("invalid range carries nonzero fields");

    a_total_needs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_total_ok) |-> r_range_valid)
        else $error("total present on invalid range");

    a_result_from_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(i_snap.vld && i_adv))
        else $error("result without a snapshot");

endmodule

@@ rtl/core/content_range_parse_check_core.sv @@
// Content-Range parse and check core: one header character per transfer.
// Timing: a new character can be taken every cycle unless stalled. A result
// passes through the input register, the parser state and snapshot register,
// then the result register. The stages advance together, so a stall on the
// result side holds the whole pipe and stalls the input in the same cycle.
// Depends on crpc_pkg, crpc_parse and crpc_check.

module content_range_parse_check_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_value_char,
    input  logic                         i_final_char,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_range_valid,
    output logic [crpc_pkg::NUM_W-1:0]   o_range_first,
    output logic [crpc_pkg::NUM_W-1:0]   o_range_last,
    output logic                         o_total_present,
    output logic [crpc_pkg::NUM_W-1:0]   o_total_length,
    output logic                         o_other_range,

    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [crpc_pkg::NUM_W-1:0]   i_cfg_data
);

    logic [crpc_pkg::NUM_W-1:0] r_req_first;
    logic [crpc_pkg::NUM_W-1:0] r_req_last;

    logic            adv;
    crpc_pkg::t_snap snap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_first <= '0;
            r_req_last  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crpc_pkg::CFG_REQ_FIRST: r_req_first <= i_cfg_data;
                crpc_pkg::CFG_REQ_LAST:  r_req_last  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // whole pipe moves unless a result is waiting on a stalled receiver
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    crpc_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_in_valid   (i_in_valid),
        .i_value_char (i_value_char),
        .i_final_char (i_final_char),
        .o_snap       (snap)
    );

    crpc_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_snap          (snap),
        .i_req_first     (r_req_first),
        .i_req_last      (r_req_last),
        .o_valid         (o_out_valid),
        .o_range_valid   (o_range_valid),
        .o_range_first   (o_range_first),
        .o_range_last    (o_range_last),
        .o_total_present (o_total_present),
        .o_total_length  (o_total_length),
        .o_other_range   (o_other_range)
    );

endmodule
